/* hw/rtl/cft_pkg.sv */
// Package for the circle flight tracker: beat payload types and fixed-point constants.
// No dependencies; used by the channel interfaces and the top level.
package cft_pkg;

    localparam int HDG_W  = 25;
    localparam int RATE_W = 20;
    localparam int TAS_W  = 16;
    localparam int RAD_W  = 24;
    localparam int DIST_W = 48;
    localparam int TURN_W = 40;
    localparam int PROD_W = 64;
    localparam int IDX_W  = 2;

    // heading units are 2^-16 degree
    localparam logic [HDG_W-1:0] FULL_CIRCLE = 25'd23592960;
    localparam logic [HDG_W-1:0] HALF_CIRCLE = 25'd11796480;
    // centimetres and Q.16 degrees to metres per radian
    localparam logic [15:0]      RADIUS_GAIN = 16'd37549;
    localparam logic [RAD_W-1:0] RADIUS_MAX  = 24'hFFFFFF;

    localparam logic [RATE_W-1:0] RATE_SHORT_RST  = 20'd9830;
    localparam logic [RATE_W-1:0] RATE_MEDIUM_RST = 20'd7864;
    localparam logic [RATE_W-1:0] RATE_LONG_RST   = 20'd6554;

    // configuration register indexes, also the preset selector codes
    localparam logic [IDX_W-1:0] REG_RATE_SHORT  = 2'd0;
    localparam logic [IDX_W-1:0] REG_RATE_MEDIUM = 2'd1;
    localparam logic [IDX_W-1:0] REG_RATE_LONG   = 2'd2;

    typedef struct packed {
        logic              restart;
        logic [IDX_W-1:0]  circle_select;
        logic [HDG_W-1:0]  heading_meas;
        logic [TAS_W-1:0]  airspeed_cms;
    } t_in_item;

    typedef struct packed {
        logic [HDG_W-1:0]  planned_heading;
        logic [HDG_W-1:0]  opposite_heading;
        logic [RAD_W-1:0]  radius_m;
    } t_out_item;

endpackage

/* hw/rtl/cft_in_if.sv */
// Input sample channel: valid/ready handshake carrying one navigation sample.
// Depends on cft_pkg for the payload type.
interface cft_in_if;
    import cft_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/cft_out_if.sv */
// Result channel: valid/ready handshake carrying planned headings and radius.
// Depends on cft_pkg for the payload type.
interface cft_out_if;
    import cft_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/circle_flight_tracker_unit.sv */
// Circle flight tracker: planned headings and turn radius estimate per sample.
// Depends on cft_pkg, cft_in_if and cft_out_if.
//
//  channel   | dir | beat contents
//  ----------+-----+---------------------------------------------------------
//  i_in      | in  | restart, circle_select, heading_meas, airspeed_cms
//  o_out     | out | planned_heading, opposite_heading, radius_m
//  i_cfg_*   | in  | write enable, register index, 20-bit rate preset
//
// A beat runs through the states in order: the accepting idle cycle updates headings
// and sums, ST_MUL_LO and ST_MUL_HI run the 24x16 multiplier, ST_DIV runs the shared
// restoring subtractor (saturation check plus 24 quotient bits), and ST_FIN loads the
// output. Zero turn skips the divide; saturation leaves it at its first step.
// i_in.ready is high only while idle; a stalled result holds only the final load.
// Reset is synchronous and active low and restores the preset defaults.
module circle_flight_tracker_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    cft_in_if.sink               i_in,
    cft_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [cft_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [cft_pkg::RATE_W-1:0] i_cfg_data
);
    import cft_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL_LO = 3'd1;
    localparam logic [2:0] ST_MUL_HI = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_FIN    = 3'd4;

    localparam logic [4:0] DIV_TOP = 5'd24;

    // wrap a signed heading once into 0..360
    function automatic logic [HDG_W-1:0] wrap_hdg(input logic signed [HDG_W+1:0] h);
        logic signed [HDG_W+1:0] w;
        begin
            w = h;
            if (h < 0) begin
                w = h + $signed({2'b00, FULL_CIRCLE});
            end else if (h >= $signed({2'b00, FULL_CIRCLE})) begin
                w = h - $signed({2'b00, FULL_CIRCLE});
            end
            return w[HDG_W-1:0];
        end
    endfunction

    logic [2:0]        r_state, n_state;
    logic [RATE_W-1:0] r_rate_short, n_rate_short;
    logic [RATE_W-1:0] r_rate_medium, n_rate_medium;
    logic [RATE_W-1:0] r_rate_long, n_rate_long;
    logic              r_pending, n_pending;
    logic [RATE_W-1:0] r_active_rate, n_active_rate;
    logic [HDG_W-1:0]  r_hdg_cw, n_hdg_cw;
    logic [HDG_W-1:0]  r_hdg_ccw, n_hdg_ccw;
    logic [DIST_W-1:0] r_dist, n_dist;
    logic [TURN_W-1:0] r_turn, n_turn;
    logic [HDG_W-1:0]  r_last, n_last;
    logic [PROD_W-1:0] r_rem, n_rem;
    logic [PROD_W-1:0] r_den, n_den;
    logic [RAD_W-1:0]  r_quo, n_quo;
    logic [4:0]        r_cnt, n_cnt;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    logic                    in_accept;
    logic                    seed;
    logic [RATE_W-1:0]       rate_use;
    logic signed [HDG_W+1:0] cw_raw, ccw_raw, delta0, delta1, delta2;
    logic [23:0]             mul_a;
    logic [TURN_W-1:0]       mul_p;
    logic [TURN_W-1:0]       turn_abs;
    logic [PROD_W:0]         diff;
    logic                    div_ge;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign in_accept   = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // shared multiplier: one distance half per cycle
    assign mul_a    = (r_state == ST_MUL_LO) ? r_dist[23:0] : r_dist[47:24];
    assign mul_p    = TURN_W'(mul_a) * TURN_W'(RADIUS_GAIN);
    assign turn_abs = r_turn[TURN_W-1] ? (~r_turn + 1'b1) : r_turn;

    // shared subtractor for the restoring divide
    assign diff   = {1'b0, r_rem} - {1'b0, r_den};
    assign div_ge = !diff[PROD_W];

    always_comb begin
        rate_use = r_active_rate;
        if (i_in.data.restart) begin
            case (i_in.data.circle_select)
                REG_RATE_SHORT:  rate_use = r_rate_short;
                REG_RATE_MEDIUM: rate_use = r_rate_medium;
                REG_RATE_LONG:   rate_use = r_rate_long;
                default:         rate_use = r_active_rate;
            endcase
        end
        seed = r_pending || i_in.data.restart;

        if (seed) begin
            cw_raw  = $signed({2'b00, i_in.data.heading_meas});
            ccw_raw = $signed({2'b00, i_in.data.heading_meas});
        end else begin
            cw_raw  = $signed({2'b00, r_hdg_cw}) + $signed({7'b0, r_active_rate});
            ccw_raw = $signed({2'b00, r_hdg_ccw}) - $signed({7'b0, r_active_rate});
        end

        // heading change, wrapped once each way
        delta0 = $signed({2'b00, i_in.data.heading_meas}) - $signed({2'b00, r_last});
        delta1 = delta0;
        if (delta0 >= $signed({2'b00, HALF_CIRCLE})) begin
            delta1 = delta0 - $signed({2'b00, FULL_CIRCLE});
        end
        delta2 = delta1;
        if (delta1 <= -$signed({2'b00, HALF_CIRCLE})) begin
            delta2 = delta1 + $signed({2'b00, FULL_CIRCLE});
        end
    end

    always_comb begin
        n_state       = r_state;
        n_rate_short  = r_rate_short;
        n_rate_medium = r_rate_medium;
        n_rate_long   = r_rate_long;
        n_pending     = r_pending;
        n_active_rate = r_active_rate;
        n_hdg_cw      = r_hdg_cw;
        n_hdg_ccw     = r_hdg_ccw;
        n_dist        = r_dist;
        n_turn        = r_turn;
        n_last        = r_last;
        n_rem         = r_rem;
        n_den         = r_den;
        n_quo         = r_quo;
        n_cnt         = r_cnt;
        n_out_valid   = r_out_valid && !o_out.ready;
        n_out         = r_out;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RATE_SHORT:  n_rate_short  = i_cfg_data;
                REG_RATE_MEDIUM: n_rate_medium = i_cfg_data;
                REG_RATE_LONG:   n_rate_long   = i_cfg_data;
                default:         ;
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_active_rate = rate_use;
                    n_pending     = 1'b0;
                    n_hdg_cw      = wrap_hdg(cw_raw);
                    n_hdg_ccw     = wrap_hdg(ccw_raw);
                    n_dist        = (seed ? '0 : r_dist) + DIST_W'(i_in.data.airspeed_cms);
                    n_turn        = (seed ? '0 : r_turn) + TURN_W'(delta2);
                    n_last        = i_in.data.heading_meas;
                    n_state       = ST_MUL_LO;
                end
            end
            ST_MUL_LO: begin
                n_rem   = PROD_W'(mul_p);
                n_den   = {turn_abs, 24'b0};
                n_state = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                n_rem = r_rem + {mul_p, 24'b0};
                n_cnt = DIV_TOP;
                if (r_turn == '0) begin
                    n_quo   = '0;
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_ge && (r_cnt == DIV_TOP)) begin
                    // quotient needs more than 24 bits: saturate
                    n_quo   = RADIUS_MAX;
                    n_state = ST_FIN;
                end else begin
                    if (div_ge) begin
                        n_rem = diff[PROD_W-1:0];
                    end
                    n_quo = {r_quo[RAD_W-2:0], div_ge};
                    n_den = r_den >> 1;
                    n_cnt = r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                // hold until the output register is free
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid           = 1'b1;
                    n_out.planned_heading  = r_hdg_cw;
                    n_out.opposite_heading = r_hdg_ccw;
                    n_out.radius_m         = r_quo;
                    n_state               = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_rate_short  <= RATE_SHORT_RST;
            r_rate_medium <= RATE_MEDIUM_RST;
            r_rate_long   <= RATE_LONG_RST;
            r_pending     <= 1'b1;
            r_active_rate <= '0;
            r_hdg_cw      <= '0;
            r_hdg_ccw     <= '0;
            r_dist        <= '0;
            r_turn        <= '0;
            r_last        <= '0;
            r_cnt         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_rate_short  <= n_rate_short;
            r_rate_medium <= n_rate_medium;
            r_rate_long   <= n_rate_long;
            r_pending     <= n_pending;
            r_active_rate <= n_active_rate;
            r_hdg_cw      <= n_hdg_cw;
            r_hdg_ccw     <= n_hdg_ccw;
            r_dist        <= n_dist;
            r_turn        <= n_turn;
            r_last        <= n_last;
            r_cnt         <= n_cnt;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_den <= n_den;
        r_quo <= n_quo;
        r_out <= n_out;
    end

    a_accept_starts_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == ST_MUL_LO))
        else $error("accepted beat did not start the multiply");

    a_headings_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_hdg_cw < FULL_CIRCLE) && (r_hdg_ccw < FULL_CIRCLE))
        else $error("planned heading left the 0..360 range");

    a_div_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_cnt <= DIV_TOP))
        else $error("divide counter out of range");

    a_zero_turn_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_FIN) && (r_turn == '0)) |-> (r_quo == '0))
        else $error("nonzero radius with zero turn");

    a_no_load_over_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> $stable(r_out))
        else $error("result register changed while its beat was stalled");

endmodule
